@@ hdl/lsf_pkg.sv @@
package lsf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_POINTS  = 4096;
    localparam int IDX_W       = $clog2(MAX_POINTS + 1);
    localparam int WIN_W       = 12;

    // Accumulator widths follow from the sample width and the point count.
    localparam int SUM_W = SAMPLE_BITS + IDX_W - 1;
    localparam int SQ_W  = 2 * SAMPLE_BITS + IDX_W - 2;
    localparam int XY_W  = 2 * SAMPLE_BITS + IDX_W - 1;

    // Word widths of the shared arithmetic units.
    localparam int OP_W   = 64;
    localparam int WIDE_W = 2 * OP_W;

    localparam int RES_W  = 48;
    localparam int CORR_W = 32;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_WINDOW,
        STATUS_ZERO_X,
        STATUS_ZERO_Y
    } t_status;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
        logic                          last;
    } t_point;

    typedef struct packed {
        t_status                  status;
        logic signed [RES_W-1:0]  slope;
        logic signed [RES_W-1:0]  intercept;
        logic [RES_W-1:0]         slope_error;
        logic [RES_W-1:0]         intercept_error;
        logic signed [CORR_W-1:0] correlation;
        logic [IDX_W-1:0]         points_used;
    } t_result;

endpackage

@@ hdl/least_squares_line_fit.sv @@
// A point is accepted when start is high and busy low; busy then stays high through S_PXX,
// S_PXY, S_PYY and S_PACC, so a new point is taken only after the previous one is accumulated.
// A point that carries last adds the final fit: up to nine shift-add multiplies,
// five restoring divides and one square root.
// The single result is strobed on o_result_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears sums and point index; window is 0 to 4095.
module least_squares_line_fit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lsf_pkg::t_point                     i_point,
    output logic                                o_result_valid,
    output lsf_pkg::t_result                    o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int SB    = lsf_pkg::SAMPLE_BITS;
    localparam int IW    = lsf_pkg::IDX_W;
    localparam int WNW   = lsf_pkg::WIN_W;
    localparam int SUMW  = lsf_pkg::SUM_W;
    localparam int SQW   = lsf_pkg::SQ_W;
    localparam int XYW   = lsf_pkg::XY_W;
    localparam int OW    = lsf_pkg::OP_W;
    localparam int WW    = lsf_pkg::WIDE_W;
    localparam int RW    = lsf_pkg::RES_W;
    localparam int CRW   = lsf_pkg::CORR_W;
    localparam int SLOPE_FRAC = 16;
    localparam int ERR_FRAC   = 32;
    localparam int CORR_FRAC  = 30;
    localparam logic [IW-1:0] MAX_IDX = IW'(lsf_pkg::MAX_POINTS);
    localparam logic [IW-1:0] TOP_IDX = IW'(lsf_pkg::MAX_POINTS - 1);
    localparam logic REG_WINDOW_LOW  = 1'b0;
    localparam logic REG_WINDOW_HIGH = 1'b1;

    typedef enum logic [2:0] {S_IDLE, S_PXX, S_PXY, S_PYY, S_PACC, S_CALC, S_FIN} t_state;

    typedef enum logic [4:0] {
        ST_NXX, ST_SXSX, ST_NXY, ST_SXSY, ST_NYY, ST_SYSY, ST_CHECK,
        ST_SYXX, ST_XYSX, ST_DIV_SLOPE, ST_DIV_SERR, ST_DIV_IERR, ST_DIV_ICPT,
        ST_CYCHK, ST_DCYY, ST_SQRT, ST_DIV_CORR
    } t_step;

    t_state                 r_state;
    t_step                  r_step;
    logic                   r_issued;
    logic                   r_valid;
    lsf_pkg::t_result       r_res;

    logic [WNW-1:0]         r_wlow;
    logic [WNW-1:0]         r_whigh;

    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_n;
    logic signed [SUMW-1:0] r_sx;
    logic signed [SUMW-1:0] r_sy;
    logic [SQW-1:0]         r_sxx;
    logic signed [XYW-1:0]  r_sxy;
    logic [SQW-1:0]         r_syy;

    logic signed [SB-1:0]   r_x;
    logic signed [SB-1:0]   r_y;
    logic                   r_last;
    logic                   r_inwin;
    logic                   r_bad;
    logic signed [2*SB-1:0] r_prod;

    logic [OW-1:0]          r_d;
    logic [OW-1:0]          r_cxy;
    logic [OW-1:0]          r_cyy;
    logic [WW-1:0]          r_t;
    logic [WW-1:0]          r_num;
    logic [OW-1:0]          r_s;

    logic                   c_accept;
    logic                   c_cfg_wr;
    logic signed [SB-1:0]   c_pa;
    logic signed [SB-1:0]   c_pb;
    logic signed [2*SB-1:0] c_mac;
    logic [IW-1:0]          c_top;

    logic [OW-1:0]          c_n64;
    logic [OW-1:0]          c_sx64;
    logic [OW-1:0]          c_sy64;
    logic [OW-1:0]          c_sxx64;
    logic [OW-1:0]          c_sxy64;
    logic [OW-1:0]          c_syy64;
    logic [OW-1:0]          c_cxy_mag;
    logic [WW-1:0]          c_num_mag;

    logic                   c_use_mul;
    logic                   c_use_div;
    logic                   c_use_sqrt;
    logic                   c_issue;
    logic [OW-1:0]          c_ma;
    logic [OW-1:0]          c_mb;
    logic [WW-1:0]          c_dnum;
    logic [OW-1:0]          c_dden;

    logic                   w_mul_done;
    logic [WW-1:0]          w_mul_prod;
    logic                   w_div_done;
    logic [OW-1:0]          w_div_quot;
    logic                   w_div_ovf;
    logic                   w_sqrt_done;
    logic [OW-1:0]          w_sqrt_root;
    logic                   c_unit_done;

    function automatic logic [RW-1:0] sat_s48(input logic neg, input logic [OW-1:0] q,
                                              input logic ovf);
        logic [OW-1:0] lim;
        logic [OW-1:0] v;
        lim = neg ? (OW'(1) << (RW - 1)) : ((OW'(1) << (RW - 1)) - 1'b1);
        v   = (ovf || q > lim) ? lim : q;
        v   = neg ? (~v + 1'b1) : v;
        return v[RW-1:0];
    endfunction

    function automatic logic [RW-1:0] sat_u48(input logic [OW-1:0] q, input logic ovf);
        logic [OW-1:0] lim;
        lim = (OW'(1) << RW) - 1'b1;
        return (ovf || q > lim) ? lim[RW-1:0] : q[RW-1:0];
    endfunction

    function automatic logic [CRW-1:0] sat_corr(input logic neg, input logic [OW-1:0] q,
                                                input logic ovf);
        logic [OW-1:0] lim;
        logic [OW-1:0] v;
        lim = OW'(1) << CORR_FRAC;
        v   = (ovf || q > lim) ? lim : q;
        v   = neg ? (~v + 1'b1) : v;
        return v[CRW-1:0];
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign c_accept = start && !busy;
    assign c_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_WINDOW_HIGH) ? {{(32-WNW){1'b0}}, r_whigh}
                                                    : {{(32-WNW){1'b0}}, r_wlow};

    // The point MAC shares one small multiplier over states S_PXX, S_PXY and S_PYY.
    assign c_pa  = (r_state == S_PYY) ? r_y : r_x;
    assign c_pb  = (r_state == S_PXX) ? r_x : r_y;
    assign c_mac = c_pa * c_pb;
    assign c_top = (r_idx < MAX_IDX) ? r_idx : TOP_IDX;

    assign c_n64   = {{(OW-IW){1'b0}}, r_n};
    assign c_sx64  = {{(OW-SUMW){r_sx[SUMW-1]}}, r_sx};
    assign c_sy64  = {{(OW-SUMW){r_sy[SUMW-1]}}, r_sy};
    assign c_sxx64 = {{(OW-SQW){1'b0}}, r_sxx};
    assign c_sxy64 = {{(OW-XYW){r_sxy[XYW-1]}}, r_sxy};
    assign c_syy64 = {{(OW-SQW){1'b0}}, r_syy};
    assign c_cxy_mag = r_cxy[OW-1] ? (~r_cxy + 1'b1) : r_cxy;
    assign c_num_mag = r_num[WW-1] ? (~r_num + 1'b1) : r_num;

    always_comb begin
        c_use_mul  = 1'b0;
        c_use_div  = 1'b0;
        c_use_sqrt = 1'b0;
        c_ma       = '0;
        c_mb       = '0;
        c_dnum     = '0;
        c_dden     = r_d;
        case (r_step)
            ST_NXX:  begin c_use_mul = 1'b1; c_ma = c_n64;  c_mb = c_sxx64; end
            ST_SXSX: begin c_use_mul = 1'b1; c_ma = c_sx64; c_mb = c_sx64;  end
            ST_NXY:  begin c_use_mul = 1'b1; c_ma = c_n64;  c_mb = c_sxy64; end
            ST_SXSY: begin c_use_mul = 1'b1; c_ma = c_sx64; c_mb = c_sy64;  end
            ST_NYY:  begin c_use_mul = 1'b1; c_ma = c_n64;  c_mb = c_syy64; end
            ST_SYSY: begin c_use_mul = 1'b1; c_ma = c_sy64; c_mb = c_sy64;  end
            ST_SYXX: begin c_use_mul = 1'b1; c_ma = c_sy64; c_mb = c_sxx64; end
            ST_XYSX: begin c_use_mul = 1'b1; c_ma = c_sxy64; c_mb = c_sx64; end
            ST_DCYY: begin c_use_mul = 1'b1; c_ma = r_d;    c_mb = r_cyy;   end
            ST_DIV_SLOPE: begin
                c_use_div = 1'b1;
                c_dnum    = {{OW{1'b0}}, c_cxy_mag} << SLOPE_FRAC;
            end
            ST_DIV_SERR: begin
                c_use_div = 1'b1;
                c_dnum    = {{(WW-IW){1'b0}}, r_n} << ERR_FRAC;
            end
            ST_DIV_IERR: begin
                c_use_div = 1'b1;
                c_dnum    = {{(WW-SQW){1'b0}}, r_sxx} << ERR_FRAC;
            end
            ST_DIV_ICPT: begin
                c_use_div = 1'b1;
                c_dnum    = c_num_mag << SLOPE_FRAC;
            end
            ST_SQRT: begin
                c_use_sqrt = 1'b1;
            end
            ST_DIV_CORR: begin
                c_use_div = 1'b1;
                c_dnum    = {{OW{1'b0}}, c_cxy_mag} << CORR_FRAC;
                c_dden    = r_s;
            end
            default: begin
                c_use_mul = 1'b0;
            end
        endcase
    end

    assign c_issue     = (r_state == S_CALC) && !r_issued;
    assign c_unit_done = w_mul_done || w_div_done || w_sqrt_done;

    lsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_issue && c_use_mul),
        .i_a     (c_ma),
        .i_b     (c_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    lsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_issue && c_use_div),
        .i_num   (c_dnum),
        .i_den   (c_dden),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_ovf   (w_div_ovf)
    );

    lsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_issue && c_use_sqrt),
        .i_rad   (r_t),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_NXX;
            r_issued <= 1'b0;
            r_valid  <= 1'b0;
            r_wlow   <= '0;
            r_whigh  <= '1;
            r_idx    <= '0;
            r_n      <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
            r_syy    <= '0;
        end else begin
            r_valid <= (r_state == S_FIN);
            if (c_cfg_wr) begin
                if (paddr[2] == REG_WINDOW_LOW) begin
                    r_wlow <= pwdata[WNW-1:0];
                end else begin
                    r_whigh <= pwdata[WNW-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (c_accept) begin
                        r_x     <= i_point.x_value;
                        r_y     <= i_point.y_value;
                        r_last  <= i_point.last;
                        r_inwin <= (r_idx < MAX_IDX) && ({1'b0, r_wlow} <= r_idx)
                                   && (r_idx <= {1'b0, r_whigh});
                        r_bad   <= (r_wlow > r_whigh) || ({1'b0, r_whigh} > c_top);
                        if (r_idx < MAX_IDX) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_state <= S_PXX;
                    end
                end
                S_PXX: begin
                    r_prod <= c_mac;
                    if (r_inwin) begin
                        r_n  <= r_n + 1'b1;
                        r_sx <= r_sx + SUMW'(r_x);
                        r_sy <= r_sy + SUMW'(r_y);
                    end
                    r_state <= S_PXY;
                end
                S_PXY: begin
                    if (r_inwin) begin
                        r_sxx <= r_sxx + {{(SQW-2*SB){1'b0}}, r_prod};
                    end
                    r_prod  <= c_mac;
                    r_state <= S_PYY;
                end
                S_PYY: begin
                    if (r_inwin) begin
                        r_sxy <= r_sxy + {{(XYW-2*SB){r_prod[2*SB-1]}}, r_prod};
                    end
                    r_prod  <= c_mac;
                    r_state <= S_PACC;
                end
                S_PACC: begin
                    if (r_inwin) begin
                        r_syy <= r_syy + {{(SQW-2*SB){1'b0}}, r_prod};
                    end
                    if (r_last) begin
                        r_res    <= lsf_pkg::t_result'{
                                        status: r_bad ? lsf_pkg::STATUS_BAD_WINDOW
                                                      : lsf_pkg::STATUS_OK,
                                        points_used: r_n,
                                        default: '0};
                        r_step   <= ST_NXX;
                        r_issued <= 1'b0;
                        if (r_bad) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (r_step == ST_CHECK) begin
                        if (r_d == '0 || r_d[OW-1]) begin
                            r_res.status <= lsf_pkg::STATUS_ZERO_X;
                            r_state      <= S_FIN;
                        end else begin
                            r_step <= ST_SYXX;
                        end
                    end else if (r_step == ST_CYCHK) begin
                        // Zero y spread keeps the line and leaves correlation at zero.
                        if (r_cyy == '0 || r_cyy[OW-1]) begin
                            r_res.status <= lsf_pkg::STATUS_ZERO_Y;
                            r_state      <= S_FIN;
                        end else begin
                            r_step <= ST_DCYY;
                        end
                    end else if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (c_unit_done) begin
                        r_issued <= 1'b0;
                        r_step   <= t_step'(r_step + 1'b1);
                        case (r_step)
                            ST_NXX:       r_t   <= w_mul_prod;
                            ST_SXSX:      r_d   <= r_t[OW-1:0] - w_mul_prod[OW-1:0];
                            ST_NXY:       r_t   <= w_mul_prod;
                            ST_SXSY:      r_cxy <= r_t[OW-1:0] - w_mul_prod[OW-1:0];
                            ST_NYY:       r_t   <= w_mul_prod;
                            ST_SYSY:      r_cyy <= r_t[OW-1:0] - w_mul_prod[OW-1:0];
                            ST_SYXX:      r_t   <= w_mul_prod;
                            ST_XYSX:      r_num <= r_t - w_mul_prod;
                            ST_DCYY:      r_t   <= w_mul_prod;
                            ST_SQRT:      r_s   <= w_sqrt_root;
                            ST_DIV_SLOPE: r_res.slope <=
                                              sat_s48(r_cxy[OW-1], w_div_quot, w_div_ovf);
                            ST_DIV_SERR:  r_res.slope_error <= sat_u48(w_div_quot, w_div_ovf);
                            ST_DIV_IERR:  r_res.intercept_error <=
                                              sat_u48(w_div_quot, w_div_ovf);
                            ST_DIV_ICPT:  r_res.intercept <=
                                              sat_s48(r_num[WW-1], w_div_quot, w_div_ovf);
                            ST_DIV_CORR: begin
                                r_res.correlation <=
                                    sat_corr(r_cxy[OW-1], w_div_quot, w_div_ovf);
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    r_idx   <= '0;
                    r_n     <= '0;
                    r_sx    <= '0;
                    r_sy    <= '0;
                    r_sxx   <= '0;
                    r_sxy   <= '0;
                    r_syy   <= '0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_res;

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_unit_done |-> (r_state == S_CALC) && r_issued)
        else $error("arithmetic unit finished with no operation outstanding");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == S_FIN)
        else $error("result strobe without a finished fit");

    a_failed_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status == lsf_pkg::STATUS_BAD_WINDOW ||
                           o_result.status == lsf_pkg::STATUS_ZERO_X)
        |-> o_result.slope == '0 && o_result.intercept == '0 && o_result.correlation == '0)
        else $error("failed fit carries nonzero numeric fields");

    a_zero_y_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == lsf_pkg::STATUS_ZERO_Y
        |-> o_result.correlation == '0)
        else $error("zero y spread with nonzero correlation");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= MAX_IDX)
        else $error("point index beyond its limit");

endmodule

@@ hdl/lsf_mul.sv @@
module lsf_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsf_pkg::OP_W-1:0]     i_a,
    input  logic [lsf_pkg::OP_W-1:0]     i_b,
    output logic                         o_done,
    output logic [lsf_pkg::WIDE_W-1:0]   o_prod
);

    localparam int OW = lsf_pkg::OP_W;
    localparam int WW = lsf_pkg::WIDE_W;
    localparam int CW = $clog2(OW);
    localparam logic [CW-1:0] LAST_STEP = CW'(OW - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_SIGN, S_DONE} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [OW-1:0]   r_mcand;
    logic [WW-1:0]   r_acc;
    logic            r_neg;

    logic [OW-1:0]   c_amag;
    logic [OW-1:0]   c_bmag;
    logic [OW:0]     c_sum;

    assign c_amag = i_a[OW-1] ? (~i_a + 1'b1) : i_a;
    assign c_bmag = i_b[OW-1] ? (~i_b + 1'b1) : i_b;
    assign c_sum  = {1'b0, r_acc[WW-1:OW]} + (r_acc[0] ? {1'b0, r_mcand} : {(OW+1){1'b0}});

    // Shift-and-add on magnitudes, one partial product per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mcand <= c_amag;
                        r_acc   <= {{OW{1'b0}}, c_bmag};
                        r_neg   <= i_a[OW-1] ^ i_b[OW-1];
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_acc <= {c_sum, r_acc[OW-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    if (r_neg) begin
                        r_acc <= ~r_acc + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_prod = r_acc;

endmodule

@@ hdl/lsf_div.sv @@
module lsf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsf_pkg::WIDE_W-1:0]   i_num,
    input  logic [lsf_pkg::OP_W-1:0]     i_den,
    output logic                         o_done,
    output logic [lsf_pkg::OP_W-1:0]     o_quot,
    output logic                         o_ovf
);

    localparam int OW = lsf_pkg::OP_W;
    localparam int WW = lsf_pkg::WIDE_W;
    localparam int CW = $clog2(WW);
    localparam logic [CW-1:0] LAST_STEP = CW'(WW - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND, S_DONE} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [WW-1:0]   r_num;
    logic [OW-1:0]   r_den;
    logic [OW-1:0]   r_rem;
    logic [OW-1:0]   r_q;
    logic            r_ovf;

    logic [OW:0]     c_rem2;
    logic [OW:0]     c_diff;
    logic            c_ge;
    logic            c_half;
    logic [OW:0]     c_inc;

    assign c_rem2 = {r_rem, r_num[WW-1]};
    assign c_diff = c_rem2 - {1'b0, r_den};
    assign c_ge   = (c_rem2 >= {1'b0, r_den});
    assign c_half = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign c_inc  = {1'b0, r_q} + 1'b1;

    // Restoring division, one quotient bit per cycle; quotient bits that
    // leave the top of the register are kept as an overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= c_ge ? c_diff[OW-1:0] : c_rem2[OW-1:0];
                    r_q   <= {r_q[OW-2:0], c_ge};
                    r_ovf <= r_ovf | r_q[OW-1];
                    r_num <= {r_num[WW-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    // Round to nearest, ties away from zero.
                    if (c_half) begin
                        r_q   <= c_inc[OW-1:0];
                        r_ovf <= r_ovf | c_inc[OW];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;

endmodule

@@ hdl/lsf_sqrt.sv @@
module lsf_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsf_pkg::WIDE_W-1:0]   i_rad,
    output logic                         o_done,
    output logic [lsf_pkg::OP_W-1:0]     o_root
);

    localparam int OW = lsf_pkg::OP_W;
    localparam int WW = lsf_pkg::WIDE_W;
    localparam int RW = OW + 4;
    localparam int CW = $clog2(OW);
    localparam logic [CW-1:0] LAST_STEP = CW'(OW - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [WW-1:0]   r_rad;
    logic [RW-1:0]   r_rem;
    logic [OW-1:0]   r_root;

    logic [RW-1:0]   c_cur;
    logic [RW-1:0]   c_trial;
    logic            c_ge;

    assign c_cur   = {r_rem[RW-3:0], r_rad[WW-1:WW-2]};
    assign c_trial = {2'b00, r_root, 2'b01};
    assign c_ge    = (c_cur >= c_trial);

    // Digit-by-digit square root: two radicand bits and one root bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rad   <= i_rad;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem  <= c_ge ? (c_cur - c_trial) : c_cur;
                    r_root <= {r_root[OW-2:0], c_ge};
                    r_rad  <= {r_rad[WW-3:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_root = r_root;

endmodule
